// ===== src/bcu_pkg.sv =====
// Package for the binomial coefficient unit: default sizes and sequencer states.
package bcu_pkg;

	localparam int BCU_N_BITS      = 8;
	localparam int BCU_RESULT_BITS = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_WAIT,
		ST_FINISH
	} bcu_state_t;

endpackage

// ===== src/bcu_in_if.sv =====
// Request channel interface: one (n, k) word per handshake.
interface bcu_in_if import bcu_pkg::*; #(
	parameter int N_BITS = BCU_N_BITS
) ();
	logic                     valid;
	logic                     ready;
	logic [N_BITS-1:0]        n_total;
	logic signed [N_BITS:0]   k_chosen;

	modport source (output valid, output n_total, output k_chosen, input ready);
	modport sink   (input valid, input n_total, input k_chosen, output ready);
endinterface

// ===== src/bcu_out_if.sv =====
// Response channel interface: one coefficient word per handshake.
interface bcu_out_if import bcu_pkg::*; #(
	parameter int RESULT_BITS = BCU_RESULT_BITS
) ();
	logic                   valid;
	logic                   ready;
	logic [RESULT_BITS-1:0] coefficient;
	logic                   overflow;

	modport source (output valid, output coefficient, output overflow, input ready);
	modport sink   (input valid, input coefficient, input overflow, output ready);
endinterface

// ===== src/bcu_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module bcu_divider import bcu_pkg::*; #(
	parameter int DIVIDEND_BITS = BCU_RESULT_BITS + BCU_N_BITS,
	parameter int DIVISOR_BITS  = BCU_N_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]  divisor,
	output logic                     done,
	output logic [DIVIDEND_BITS-1:0] quotient
);
	localparam int CW = $clog2(DIVIDEND_BITS + 1);

	logic                     busy_q;
	logic [CW-1:0]            cnt_q;
	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [DIVISOR_BITS-1:0]  div_q;
	logic [DIVIDEND_BITS-1:0] quo_q;

	logic [DIVISOR_BITS:0]    trial;
	logic [DIVISOR_BITS:0]    diff;
	logic                     ge;

	assign trial = {rem_q, quo_q[DIVIDEND_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DIVIDEND_BITS);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], ge};
		end
	end
endmodule

// ===== src/binomial_coefficient_unit.sv =====
// Top level of the binomial coefficient unit: sequencer, multiplier and shared divider.
// Computes C(n,k) exactly. Negative k or k above n returns 0; otherwise the unit
// takes b = max(k, n-k) and s = min(k, n-k) and runs s steps from 1, each
// step multiplying the running value by b+i and dividing exactly by i. One
// multiply and one radix-2 restoring divide share the loop; the divide
// produces one quotient bit per cycle over RESULT_BITS+N_BITS bits. A result
// that no longer fits in RESULT_BITS bits stops the loop early and returns all
// ones with overflow set. With default sizes every running value C(b+i, i)
// passes 64 bits by step 34 at the latest, so no item runs more than 34 steps
// and the slowest one is n=68, k=34. The request channel is ready only while
// no item is in work; a finished word waits in an output register, so a new
// request is taken while the response is still unread.
module binomial_coefficient_unit import bcu_pkg::*; #(
	parameter int N_BITS      = BCU_N_BITS,
	parameter int RESULT_BITS = BCU_RESULT_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	bcu_in_if.sink     req,
	bcu_out_if.source  rsp
);
	localparam int PW = RESULT_BITS + N_BITS;   // product width

	bcu_state_t state_q, state_d;

	// latched request
	logic [N_BITS-1:0]      n_q;
	logic [N_BITS:0]        k_q;
	// loop state
	logic [N_BITS-1:0]      base_q;
	logic [N_BITS-1:0]      steps_q;
	logic [N_BITS-1:0]      i_q;
	logic [RESULT_BITS-1:0] val_q;
	logic [PW-1:0]          prod_q;
	// pending result
	logic [RESULT_BITS-1:0] res_q;
	logic                   res_ovf_q;
	// output register
	logic                   out_valid_q;
	logic [RESULT_BITS-1:0] out_coef_q;
	logic                   out_ovf_q;

	logic                   accept;
	logic                   div_start;
	logic                   div_done;
	logic [PW-1:0]          div_quo;
	logic                   load_out;
	logic                   slot_free;

	logic [N_BITS-1:0]      k_mag;
	logic [N_BITS-1:0]      n_minus_k;
	logic                   k_zero_case;
	logic [N_BITS-1:0]      mult;
	logic                   quo_ovf;

	assign k_mag       = k_q[N_BITS-1:0];
	assign n_minus_k   = n_q - k_mag;
	assign k_zero_case = k_q[N_BITS] || (k_mag > n_q);
	// b+i never exceeds n, so it fits in N_BITS bits
	assign mult        = base_q + i_q;
	assign quo_ovf     = (div_quo[PW-1:RESULT_BITS] != '0);
	assign slot_free   = !out_valid_q || rsp.ready;
	assign accept      = req.valid && req.ready;

	bcu_divider #(
		.DIVIDEND_BITS (PW),
		.DIVISOR_BITS  (N_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (i_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid)
					state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = k_zero_case ? ST_FINISH : ST_CHECK;
			end
			ST_CHECK: begin
				state_d = (i_q > steps_q) ? ST_FINISH : ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				div_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done)
					state_d = quo_ovf ? ST_FINISH : ST_CHECK;
			end
			ST_FINISH: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= req.n_total;
			k_q <= req.k_chosen;
		end
		unique case (state_q)
			ST_SETUP: begin
				res_q     <= '0;
				res_ovf_q <= 1'b0;
				val_q     <= RESULT_BITS'(1);
				i_q       <= N_BITS'(1);
				if (k_mag < n_minus_k) begin
					base_q  <= n_minus_k;
					steps_q <= k_mag;
				end else begin
					base_q  <= k_mag;
					steps_q <= n_minus_k;
				end
			end
			ST_CHECK: begin
				if (i_q > steps_q)
					res_q <= val_q;
			end
			ST_MUL: begin
				prod_q <= val_q * mult;
			end
			ST_WAIT: begin
				if (div_done) begin
					if (quo_ovf) begin
						res_q     <= '1;
						res_ovf_q <= 1'b1;
					end else begin
						val_q <= div_quo[RESULT_BITS-1:0];
						i_q   <= i_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_coef_q <= res_q;
			out_ovf_q  <= res_ovf_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.coefficient = out_coef_q;
	assign rsp.overflow    = out_ovf_q;
endmodule
